### hw/rtl/osr_pkg.sv
// Shared types and constants for the output-port shadow registry.
`timescale 1ns / 1ps

package osr_pkg;

    localparam int MAX_PORTS       = 64;
    localparam int HARD_SLOT_LIMIT = 100;
    localparam int SLOT_LIMIT      = (MAX_PORTS < HARD_SLOT_LIMIT) ? MAX_PORTS : HARD_SLOT_LIMIT;
    localparam int SLOT_W          = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int CNT_W           = $clog2(MAX_PORTS + 1);
    localparam int PORT_W          = 16;
    localparam int WIDE_BITS       = 32;
    localparam int BYTE_BITS       = 8;

    localparam logic [PORT_W-1:0] WIDE_PORT_LIMIT = 16'h0210;

    typedef enum logic [2:0] {
        K_BIT_SET     = 3'd0,
        K_BIT_CLR     = 3'd1,
        K_WORD_WR     = 3'd2,
        K_BIT_STATUS  = 3'd3,
        K_BYTE_STATUS = 3'd4,
        K_BACKUP      = 3'd5,
        K_RESTORE     = 3'd6,
        K_NOP         = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        RC_OK        = 3'd0,
        RC_DISABLED  = 3'd1,
        RC_PORT_ZERO = 3'd2,
        RC_BIT_RANGE = 3'd3,
        RC_FULL      = 3'd4
    } t_rc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_MODIFY,
        ST_BACKUP,
        ST_RESTORE
    } t_state;

    typedef struct packed {
        logic [WIDE_BITS-1:0] wide;
        logic [BYTE_BITS-1:0] narrow;
    } t_shadow;

    typedef struct packed {
        logic              tbl_we;
        logic [SLOT_W-1:0] tbl_waddr;
        logic [PORT_W-1:0] tbl_wdata;
        logic [SLOT_W-1:0] tbl_raddr;
        logic              sh_we;
        logic [SLOT_W-1:0] sh_waddr;
        t_shadow           sh_wdata;
        logic [SLOT_W-1:0] sh_raddr;
        logic              bk_we;
        logic [SLOT_W-1:0] bk_waddr;
        t_shadow           bk_wdata;
        logic [SLOT_W-1:0] bk_raddr;
    } t_store_ctl;

endpackage

### hw/rtl/osr_store.sv
// Slot table, plus shadow and backup memories that have per-entry valid bits.
`timescale 1ns / 1ps

module osr_store
    import osr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_ctl        i_ctl,
    output logic [PORT_W-1:0] o_tbl_rdata,
    output t_shadow           o_sh_rdata,
    output t_shadow           o_bk_rdata
);

    logic [PORT_W-1:0] r_tbl_mem [MAX_PORTS];
    t_shadow           r_sh_mem  [MAX_PORTS];
    t_shadow           r_bk_mem  [MAX_PORTS];

    logic [MAX_PORTS-1:0] r_sh_vld;
    logic [MAX_PORTS-1:0] r_bk_vld;

    logic [PORT_W-1:0] r_tbl_rd;
    t_shadow           r_sh_rd;
    t_shadow           r_bk_rd;
    logic              r_sh_rd_vld;
    logic              r_bk_rd_vld;

    // memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (i_ctl.tbl_we) begin
            r_tbl_mem[i_ctl.tbl_waddr] <= i_ctl.tbl_wdata;
        end
        if (i_ctl.sh_we) begin
            r_sh_mem[i_ctl.sh_waddr] <= i_ctl.sh_wdata;
        end
        if (i_ctl.bk_we) begin
            r_bk_mem[i_ctl.bk_waddr] <= i_ctl.bk_wdata;
        end
        r_tbl_rd <= r_tbl_mem[i_ctl.tbl_raddr];
        r_sh_rd  <= r_sh_mem[i_ctl.sh_raddr];
        r_bk_rd  <= r_bk_mem[i_ctl.bk_raddr];
    end

    // a shadow or backup entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld    <= '0;
            r_bk_vld    <= '0;
            r_sh_rd_vld <= 1'b0;
            r_bk_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.sh_we) begin
                r_sh_vld[i_ctl.sh_waddr] <= 1'b1;
            end
            if (i_ctl.bk_we) begin
                r_bk_vld[i_ctl.bk_waddr] <= 1'b1;
            end
            r_sh_rd_vld <= r_sh_vld[i_ctl.sh_raddr];
            r_bk_rd_vld <= r_bk_vld[i_ctl.bk_raddr];
        end
    end

    assign o_tbl_rdata = r_tbl_rd;
    assign o_sh_rdata  = r_sh_rd_vld ? r_sh_rd : '0;
    assign o_bk_rdata  = r_bk_rd_vld ? r_bk_rd : '0;

endmodule

### hw/rtl/osr_alu.sv
// Shared unit: slot-search compare, shadow bit/word update and status-bit read.
`timescale 1ns / 1ps

module osr_alu
    import osr_pkg::*;
(
    input  t_kind                i_kind,
    input  logic                 i_wide,
    input  logic [5:0]           i_bit,
    input  logic [WIDE_BITS-1:0] i_value,
    input  t_shadow              i_shadow,
    input  logic [PORT_W-1:0]    i_tbl_port,
    input  logic [PORT_W-1:0]    i_key_port,
    output logic                 o_match,
    output t_shadow              o_shadow,
    output logic                 o_status_bit
);

    logic [WIDE_BITS-1:0] mask_wide;
    logic [BYTE_BITS-1:0] mask_byte;

    assign o_match   = (i_tbl_port == i_key_port);
    assign mask_wide = {{(WIDE_BITS-1){1'b0}}, 1'b1} << i_bit[4:0];
    assign mask_byte = {{(BYTE_BITS-1){1'b0}}, 1'b1} << i_bit[2:0];

    always_comb begin
        o_shadow = i_shadow;
        case (i_kind)
            K_BIT_SET: begin
                if (i_wide) o_shadow.wide   = i_shadow.wide | mask_wide;
                else        o_shadow.narrow = i_shadow.narrow | mask_byte;
            end
            K_BIT_CLR: begin
                if (i_wide) o_shadow.wide   = i_shadow.wide & ~mask_wide;
                else        o_shadow.narrow = i_shadow.narrow & ~mask_byte;
            end
            K_WORD_WR: begin
                if (i_wide) o_shadow.wide   = i_value;
                else        o_shadow.narrow = i_value[BYTE_BITS-1:0];
            end
            default: begin
                o_shadow = i_shadow;
            end
        endcase
    end

    assign o_status_bit = i_wide ? i_shadow.wide[i_bit[4:0]] : i_shadow.narrow[i_bit[2:0]];

endmodule

### hw/rtl/output_port_shadow_registry_core.sv
// Output-port shadow registry: top level with the item sequencer.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Each result appears for
// one cycle with o_result_valid high and cannot be held off; o_last marks the
// final result of an item. Rejected items (access disabled, port zero, bit out
// of range), no-ops and backup/restore with no slots registered give their
// single result in the cycle after acceptance and never raise busy. A port
// access searches the slot table one entry a cycle through the shared compare
// unit. Backup and restore walk the registered slots at one slot a cycle
// through the single read port of each memory, restore giving one result per
// slot. The disable register must be written through i_cfg_we / i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module output_port_shadow_registry_core
    import osr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_kind,
    input  logic [PORT_W-1:0]    i_port,
    input  logic [5:0]           i_bit_index,
    input  logic [WIDE_BITS-1:0] i_write_value,
    output logic                 o_result_valid,
    output logic [2:0]           o_result_code,
    output logic                 o_write_valid,
    output logic [PORT_W-1:0]    o_write_port,
    output logic [BYTE_BITS-1:0] o_write_data,
    output logic                 o_status_bit,
    output logic [BYTE_BITS-1:0] o_status_byte,
    output logic                 o_last
);

    t_state r_state, n_state;
    logic   r_disabled;

    // captured item
    t_kind                r_kind;
    logic [PORT_W-1:0]    r_port;
    logic [5:0]           r_bit;
    logic [WIDE_BITS-1:0] r_value;

    // walk / search control
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [SLOT_W-1:0] r_pend_idx, n_pend_idx;
    logic [SLOT_W-1:0] r_slot, n_slot;

    // result register
    logic                 r_res_vld, n_res_vld;
    t_rc                  r_res_code, n_res_code;
    logic                 r_res_wv, n_res_wv;
    logic [PORT_W-1:0]    r_res_wport, n_res_wport;
    logic [BYTE_BITS-1:0] r_res_wdata, n_res_wdata;
    logic                 r_res_sbit, n_res_sbit;
    logic [BYTE_BITS-1:0] r_res_sbyte, n_res_sbyte;
    logic                 r_res_last, n_res_last;

    t_store_ctl        ctl;
    logic [PORT_W-1:0] tbl_rdata;
    t_shadow           sh_rdata;
    t_shadow           bk_rdata;

    logic    alu_match;
    t_shadow alu_shadow;
    logic    alu_sbit;

    t_kind in_kind;
    logic  in_wide;
    logic  in_bad_bit;
    logic  item_wide;
    logic  issue;
    logic  accept;

    assign in_kind = t_kind'(i_kind);
    assign in_wide = (i_port < WIDE_PORT_LIMIT);
    assign in_bad_bit = (in_kind inside {K_BIT_SET, K_BIT_CLR, K_BIT_STATUS}) &&
                        (in_wide ? (i_bit_index >= 6'(WIDE_BITS))
                                 : (i_bit_index >= 6'(BYTE_BITS)));
    assign item_wide = (r_port < WIDE_PORT_LIMIT);
    assign issue  = (r_idx < r_count);   // another slot left to read
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    osr_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_tbl_rdata (tbl_rdata),
        .o_sh_rdata  (sh_rdata),
        .o_bk_rdata  (bk_rdata)
    );

    osr_alu u_alu (
        .i_kind       (r_kind),
        .i_wide       (item_wide),
        .i_bit        (r_bit),
        .i_value      (r_value),
        .i_shadow     (sh_rdata),
        .i_tbl_port   (tbl_rdata),
        .i_key_port   (r_port),
        .o_match      (alu_match),
        .o_shadow     (alu_shadow),
        .o_status_bit (alu_sbit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && !r_disabled) begin
                    case (in_kind)
                        K_BACKUP: begin
                            if (r_count != '0) n_state = ST_BACKUP;
                        end
                        K_RESTORE: begin
                            if (r_count != '0) n_state = ST_RESTORE;
                        end
                        K_NOP: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            if (i_port != '0 && !in_bad_bit) n_state = ST_SEARCH;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (r_pend && alu_match) begin
                    n_state = ST_READ;
                end else if (!issue) begin
                    n_state = (r_count >= CNT_W'(SLOT_LIMIT)) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:   n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_IDLE;
            ST_BACKUP, ST_RESTORE: begin
                if (r_pend && !issue) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath, memory control and results
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[SLOT_W-1:0];
        n_slot      = r_slot;
        n_res_vld   = 1'b0;
        n_res_code  = RC_OK;
        n_res_wv    = 1'b0;
        n_res_wport = '0;
        n_res_wdata = '0;
        n_res_sbit  = 1'b0;
        n_res_sbyte = '0;
        n_res_last  = 1'b1;

        ctl           = '0;
        ctl.tbl_raddr = r_idx[SLOT_W-1:0];
        ctl.bk_raddr  = r_idx[SLOT_W-1:0];
        ctl.sh_raddr  = (r_state == ST_READ) ? r_slot : r_idx[SLOT_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_idx = '0;
                    if (r_disabled) begin
                        n_res_vld  = 1'b1;
                        n_res_code = RC_DISABLED;
                    end else begin
                        case (in_kind)
                            K_BACKUP, K_RESTORE: begin
                                n_res_vld = (r_count == '0);
                            end
                            K_NOP: begin
                                n_res_vld = 1'b1;
                            end
                            default: begin
                                if (i_port == '0) begin
                                    n_res_vld  = 1'b1;
                                    n_res_code = RC_PORT_ZERO;
                                end else if (in_bad_bit) begin
                                    n_res_vld  = 1'b1;
                                    n_res_code = RC_BIT_RANGE;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_SEARCH: begin
                n_idx  = r_idx + CNT_W'(issue);
                n_pend = issue;
                if (r_pend && alu_match) begin
                    n_slot = r_pend_idx;
                end else if (!issue) begin
                    if (r_count >= CNT_W'(SLOT_LIMIT)) begin
                        n_res_vld  = 1'b1;
                        n_res_code = RC_FULL;
                    end else begin
                        // new port takes the next free slot
                        ctl.tbl_we    = 1'b1;
                        ctl.tbl_waddr = r_count[SLOT_W-1:0];
                        ctl.tbl_wdata = r_port;
                        n_slot        = r_count[SLOT_W-1:0];
                        n_count       = r_count + CNT_W'(1);
                    end
                end
            end
            ST_READ: begin
                n_slot = r_slot;
            end
            ST_MODIFY: begin
                n_res_vld = 1'b1;
                case (r_kind)
                    K_BIT_SET, K_BIT_CLR, K_WORD_WR: begin
                        ctl.sh_we    = 1'b1;
                        ctl.sh_waddr = r_slot;
                        ctl.sh_wdata = alu_shadow;
                        if (!item_wide) begin
                            n_res_wv    = 1'b1;
                            n_res_wport = r_port;
                            n_res_wdata = alu_shadow.narrow;
                        end
                    end
                    K_BIT_STATUS: begin
                        n_res_sbit = alu_sbit;
                    end
                    K_BYTE_STATUS: begin
                        n_res_sbyte = sh_rdata.narrow;
                    end
                    default: begin
                        n_res_code = RC_OK;
                    end
                endcase
            end
            ST_BACKUP: begin
                n_idx  = r_idx + CNT_W'(issue);
                n_pend = issue;
                if (r_pend) begin
                    ctl.bk_we    = 1'b1;
                    ctl.bk_waddr = r_pend_idx;
                    ctl.bk_wdata = sh_rdata;
                    n_res_vld    = !issue;
                end
            end
            ST_RESTORE: begin
                n_idx  = r_idx + CNT_W'(issue);
                n_pend = issue;
                if (r_pend) begin
                    ctl.sh_we    = 1'b1;
                    ctl.sh_waddr = r_pend_idx;
                    ctl.sh_wdata = bk_rdata;
                    n_res_vld    = 1'b1;
                    n_res_last   = !issue;
                    if (tbl_rdata >= WIDE_PORT_LIMIT) begin
                        n_res_wv    = 1'b1;
                        n_res_wport = tbl_rdata;
                        n_res_wdata = bk_rdata.narrow;
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_disabled <= 1'b0;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_disabled <= i_cfg_wdata;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= in_kind;
            r_port  <= i_port;
            r_bit   <= i_bit_index;
            r_value <= i_write_value;
        end
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_slot      <= n_slot;
        r_res_code  <= n_res_code;
        r_res_wv    <= n_res_wv;
        r_res_wport <= n_res_wport;
        r_res_wdata <= n_res_wdata;
        r_res_sbit  <= n_res_sbit;
        r_res_sbyte <= n_res_sbyte;
        r_res_last  <= n_res_last;
    end

    assign o_result_valid = r_res_vld;
    assign o_result_code  = r_res_code;
    assign o_write_valid  = r_res_wv;
    assign o_write_port   = r_res_wport;
    assign o_write_data   = r_res_wdata;
    assign o_status_bit   = r_res_sbit;
    assign o_status_byte  = r_res_sbyte;
    assign o_last         = r_res_last;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOT_LIMIT))
        else $error("slot count beyond limit");

    a_item_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_result_valid))
        else $error("accepted item neither running nor answered");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_result_valid && o_last))
        else $error("sequence ended without a final result");

    a_midrun_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> (r_state == ST_RESTORE))
        else $error("non-final result outside a restore walk");
`endif

endmodule

### bench/output_port_shadow_registry_core_tb.sv
// Self-checking testbench for the output-port shadow registry core.
`timescale 1ns / 1ps

// Items go in on the start/busy handshake and each result strobe is checked
// against a scoreboard filled by an in-bench model of the registry. That model
// holds its own copy of the slot table, both shadows and both backups.
// Inputs change on the falling edge and results are sampled on the rising edge.
module output_port_shadow_registry_core_tb;
    import osr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    // Longest item is a port access over a full table.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;
    // A restore walk reports at most this many slots.
    localparam int RESTORE_REPORT_LIMIT = 64;
    localparam int POOL_SIZE     = 12;

    typedef struct {
        t_rc                  code;
        logic                 write_valid;
        logic [PORT_W-1:0]    write_port;
        logic [BYTE_BITS-1:0] write_data;
        logic                 status_bit;
        logic [BYTE_BITS-1:0] status_byte;
        logic                 last;
    } t_port_result;

    // ---------------------------------------------------------------- DUT I/O
    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_wdata   = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [2:0]           i_kind        = '0;
    logic [PORT_W-1:0]    i_port        = '0;
    logic [5:0]           i_bit_index   = '0;
    logic [WIDE_BITS-1:0] i_write_value = '0;
    logic                 o_result_valid;
    logic [2:0]           o_result_code;
    logic                 o_write_valid;
    logic [PORT_W-1:0]    o_write_port;
    logic [BYTE_BITS-1:0] o_write_data;
    logic                 o_status_bit;
    logic [BYTE_BITS-1:0] o_status_byte;
    logic                 o_last;

    output_port_shadow_registry_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_port         (i_port),
        .i_bit_index    (i_bit_index),
        .i_write_value  (i_write_value),
        .o_result_valid (o_result_valid),
        .o_result_code  (o_result_code),
        .o_write_valid  (o_write_valid),
        .o_write_port   (o_write_port),
        .o_write_data   (o_write_data),
        .o_status_bit   (o_status_bit),
        .o_status_byte  (o_status_byte),
        .o_last         (o_last)
    );

    // ------------------------------------------------------- registry model
    logic                 access_disabled = 1'b0;
    logic [PORT_W-1:0]    slot_port   [MAX_PORTS];
    int                   slots_used;
    logic [WIDE_BITS-1:0] wide_shadow [MAX_PORTS];
    logic [BYTE_BITS-1:0] byte_shadow [MAX_PORTS];
    logic [WIDE_BITS-1:0] wide_backup [MAX_PORTS];
    logic [BYTE_BITS-1:0] byte_backup [MAX_PORTS];

    t_port_result pending_results[$];

    int   error_count  = 0;
    int   items_sent   = 0;
    int   results_seen = 0;
    int   cycle_count  = 0;
    logic burst_mode   = 1'b0;

    // Wide ports first, then byte ports. 0x5555/0xAAAA toggle every port bit.
    logic [PORT_W-1:0] port_pool [POOL_SIZE] = '{
        16'h0001, 16'h020F, 16'h0100, 16'h0080, 16'h01AA, 16'h0055,
        16'h0210, 16'hFFFF, 16'h0378, 16'h8000, 16'h5555, 16'hAAAA
    };

    function automatic t_port_result port_result(
        input t_rc code, input logic wv, input logic [PORT_W-1:0] wp,
        input logic [BYTE_BITS-1:0] wd, input logic sb,
        input logic [BYTE_BITS-1:0] sy, input logic last);
        t_port_result r;
        r.code        = code;
        r.write_valid = wv;
        r.write_port  = wp;
        r.write_data  = wd;
        r.status_bit  = sb;
        r.status_byte = sy;
        r.last        = last;
        return r;
    endfunction

    function automatic int slot_of_port(input logic [PORT_W-1:0] port);
        for (int i = 0; i < slots_used; i++)
            if (slot_port[i] == port) return i;
        return -1;
    endfunction

    // Slot of the port, taking the next free one for a new port; -1 when full.
    function automatic int claim_slot(input logic [PORT_W-1:0] port);
        int slot;
        slot = slot_of_port(port);
        if (slot >= 0) return slot;
        if (slots_used >= SLOT_LIMIT) return -1;
        slot_port[slots_used] = port;
        slots_used++;
        return slots_used - 1;
    endfunction

    // Works out the results of one accepted item and queues them.
    task automatic predict_port_item(input t_kind kind, input logic [PORT_W-1:0] port,
                                     input logic [5:0] bit_idx,
                                     input logic [WIDE_BITS-1:0] value);
        logic                 wide;
        logic                 byte_port;
        logic                 stat;
        int                   slot;
        logic [WIDE_BITS-1:0] wmask;
        logic [BYTE_BITS-1:0] bmask;
        wide = port < WIDE_PORT_LIMIT;
        if (access_disabled) begin
            pending_results.push_back(port_result(RC_DISABLED, 0, '0, '0, 0, '0, 1));
        end else if (kind == K_BACKUP) begin
            wide_backup = wide_shadow;
            byte_backup = byte_shadow;
            pending_results.push_back(port_result(RC_OK, 0, '0, '0, 0, '0, 1));
        end else if (kind == K_RESTORE) begin
            if (slots_used == 0)
                pending_results.push_back(port_result(RC_OK, 0, '0, '0, 0, '0, 1));
            for (int i = 0; i < slots_used; i++) begin
                wide_shadow[i] = wide_backup[i];
                byte_shadow[i] = byte_backup[i];
                if (i < RESTORE_REPORT_LIMIT) begin
                    byte_port = slot_port[i] >= WIDE_PORT_LIMIT;
                    pending_results.push_back(port_result(RC_OK, byte_port,
                        byte_port ? slot_port[i] : '0, byte_port ? byte_shadow[i] : '0,
                        0, '0, (i + 1 == slots_used) || (i + 1 == RESTORE_REPORT_LIMIT)));
                end
            end
        end else if (kind == K_NOP) begin
            pending_results.push_back(port_result(RC_OK, 0, '0, '0, 0, '0, 1));
        end else if (port == '0) begin
            pending_results.push_back(port_result(RC_PORT_ZERO, 0, '0, '0, 0, '0, 1));
        end else if ((kind inside {K_BIT_SET, K_BIT_CLR, K_BIT_STATUS}) &&
                     (bit_idx >= (wide ? WIDE_BITS : BYTE_BITS))) begin
            pending_results.push_back(port_result(RC_BIT_RANGE, 0, '0, '0, 0, '0, 1));
        end else begin
            // bit range is judged before registration, so only in-range items claim
            slot = claim_slot(port);
            if (slot < 0) begin
                pending_results.push_back(port_result(RC_FULL, 0, '0, '0, 0, '0, 1));
            end else begin
                wmask = 32'd1 << bit_idx;
                bmask = 8'd1 << bit_idx[2:0];
                case (kind)
                    K_BIT_SET, K_BIT_CLR, K_WORD_WR: begin
                        if (wide) begin
                            if (kind == K_BIT_SET)      wide_shadow[slot] |= wmask;
                            else if (kind == K_BIT_CLR) wide_shadow[slot] &= ~wmask;
                            else                        wide_shadow[slot] = value;
                            pending_results.push_back(port_result(RC_OK, 0, '0, '0, 0, '0, 1));
                        end else begin
                            if (kind == K_BIT_SET)      byte_shadow[slot] |= bmask;
                            else if (kind == K_BIT_CLR) byte_shadow[slot] &= ~bmask;
                            else                        byte_shadow[slot] = value[7:0];
                            // every byte-port change goes out as a hardware write
                            pending_results.push_back(port_result(RC_OK, 1, port,
                                byte_shadow[slot], 0, '0, 1));
                        end
                    end
                    K_BIT_STATUS: begin
                        stat = wide ? wide_shadow[slot][bit_idx[4:0]]
                                    : byte_shadow[slot][bit_idx[2:0]];
                        pending_results.push_back(port_result(RC_OK, 0, '0, '0, stat, '0, 1));
                    end
                    default: begin
                        // byte status gives the 8-bit shadow even on a wide port
                        pending_results.push_back(port_result(RC_OK, 0, '0, '0, 0,
                            byte_shadow[slot], 1));
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------- clock, watchdog
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("output_port_shadow_registry_core_tb: errors");
        $finish;
    end

    // ------------------------------------------------------- result checker
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_port_result want;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result_code: expected no result, got 0x%0h", o_result_code);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_code", want.code,        o_result_code);
                check_field("write_valid", want.write_valid, o_write_valid);
                check_field("write_port",  want.write_port,  o_write_port);
                check_field("write_data",  want.write_data,  o_write_data);
                check_field("status_bit",  want.status_bit,  o_status_bit);
                check_field("status_byte", want.status_byte, o_status_byte);
                check_field("last",        want.last,        o_last);
            end
        end
    end

    // ------------------------------------------------------- sender side
    // Mostly back to back or short gaps, now and then a long one.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Start stays high after acceptance; the next negedge either lowers it
    // or presents the next item.
    task automatic send_item(input t_kind kind, input logic [PORT_W-1:0] port,
                             input logic [5:0] bit_idx, input logic [WIDE_BITS-1:0] value);
        @(negedge i_clk);
        start         <= 1'b1;
        i_kind        <= kind;
        i_port        <= port;
        i_bit_index   <= bit_idx;
        i_write_value <= value;
        // busy only moves on a rising edge, so it is steady here
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_port_item(kind, port, bit_idx, value);
        items_sent++;
        pause_sender(sender_gap());
    endtask

    // Hold off until every queued result is in, then let the block settle.
    task automatic wait_for_quiet();
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        pause_sender(SETTLE_CYCLES);
    endtask

    task automatic set_access_disabled(input logic disabled);
        wait_for_quiet();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= disabled;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        access_disabled = disabled;
    endtask

    task automatic send_random_item();
        int                   pick;
        t_kind                kind;
        logic [PORT_W-1:0]    port;
        logic [5:0]           bit_idx;
        logic [WIDE_BITS-1:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 18)      kind = K_BIT_SET;
        else if (pick < 32) kind = K_BIT_CLR;
        else if (pick < 50) kind = K_WORD_WR;
        else if (pick < 66) kind = K_BIT_STATUS;
        else if (pick < 78) kind = K_BYTE_STATUS;
        else if (pick < 87) kind = K_BACKUP;
        else if (pick < 96) kind = K_RESTORE;
        else                kind = K_NOP;
        pick = $urandom_range(0, 99);
        if (pick < 85)      port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 90) port = '0;
        else                port = 16'($urandom_range(1, 65535));
        // mostly in range so that the shadows move; the rest anywhere in 0..63
        pick = $urandom_range(0, 99);
        if (pick < 80)
            bit_idx = (port < WIDE_PORT_LIMIT) ? 6'($urandom_range(0, 31))
                                               : 6'($urandom_range(0, 7));
        else
            bit_idx = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 5)       value = '0;
        else if (pick < 10) value = '1;
        else                value = $urandom();
        send_item(kind, port, bit_idx, value);
    endtask

    task automatic run_random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 15 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if (i % 25 == 24) wait_for_quiet();
            send_random_item();
        end
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------- tests
    task automatic test_directed_basics();
        send_item(K_RESTORE, '0, '0, '0);                     // nothing registered
        send_item(K_BACKUP, '0, '0, '0);
        send_item(K_NOP, 16'h1234, 6'd63, '1);
        send_item(K_BIT_SET, 16'h0000, 6'd0, '0);             // port zero
        send_item(K_BIT_SET, 16'h0001, 6'd31, '0);
        send_item(K_BIT_SET, 16'h0001, 6'd32, '0);            // wide range edge
        send_item(K_BIT_CLR, 16'hFFFF, 6'd8, '0);             // byte range edge
        send_item(K_WORD_WR, 16'h020F, 6'd0, 32'hFFFF_FFFF);
        send_item(K_WORD_WR, 16'h0210, 6'd0, 32'hA5A5_A5A5);  // truncated to a byte
        send_item(K_BIT_SET, 16'h0210, 6'd7, '0);
        send_item(K_BIT_CLR, 16'h0210, 6'd0, '0);
        send_item(K_BIT_CLR, 16'h020F, 6'd0, '0);
        send_item(K_BIT_STATUS, 16'h020F, 6'd31, '0);
        send_item(K_BIT_STATUS, 16'h020F, 6'd0, '0);
        send_item(K_BYTE_STATUS, 16'h020F, 6'd0, '0);         // byte shadow of wide port
        send_item(K_BIT_STATUS, 16'hFFFF, 6'd63, '0);
        send_item(K_BIT_STATUS, 16'hFFFF, 6'd7, '0);          // a read registers too
        send_item(K_BYTE_STATUS, 16'h0210, 6'd0, '0);
        send_item(K_BACKUP, '0, '0, '0);
        send_item(K_WORD_WR, 16'h0210, 6'd0, '0);
        send_item(K_WORD_WR, 16'h020F, 6'd0, '0);
        send_item(K_RESTORE, '0, '0, '0);                     // both shadows come back
        send_item(K_BYTE_STATUS, 16'h0210, 6'd0, '0);
    endtask

    task automatic test_access_disabled();
        set_access_disabled(1'b1);
        for (int k = 0; k < 8; k++)
            send_item(t_kind'(k), 16'($urandom()), 6'($urandom()), $urandom());
        set_access_disabled(1'b0);
    endtask

    task automatic test_random_small_table();
        run_random_items(12);
    endtask

    // Registers the pool, then fresh ports until the table is full; new ports
    // are then refused by every registering kind, and a restore walks it all.
    task automatic test_table_full();
        logic [PORT_W-1:0] port;
        for (int i = 0; i < POOL_SIZE && slots_used < SLOT_LIMIT; i++)
            send_item(K_WORD_WR, port_pool[i], '0, $urandom());
        while (slots_used < SLOT_LIMIT) begin
            do port = 16'($urandom_range(1, 65535)); while (slot_of_port(port) >= 0);
            send_item(K_WORD_WR, port, '0, $urandom());
        end
        do port = 16'($urandom_range(1, 65535)); while (slot_of_port(port) >= 0);
        for (int k = 0; k <= 4; k++)
            send_item(t_kind'(k), port, 6'd0, $urandom());
        send_item(K_BACKUP, '0, '0, '0);
        send_item(K_RESTORE, '0, '0, '0);
        send_item(K_RESTORE, '0, '0, '0);
    endtask

    task automatic test_random_full_table();
        run_random_items(5);
        set_access_disabled(1'b1);
        run_random_items(2);
        set_access_disabled(1'b0);
        run_random_items(5);
    endtask

    // ------------------------------------------------------- main sequence
    initial begin
        slot_port   = '{default: '0};
        slots_used  = 0;
        wide_shadow = '{default: '0};
        byte_shadow = '{default: '0};
        wide_backup = '{default: '0};
        byte_backup = '{default: '0};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_access_disabled();
        test_random_small_table();
        test_table_full();
        test_random_full_table();
        wait_for_quiet();

        $display("Ran %0d items, %0d results: all kinds, rejects, access disable and",
                 items_sent, results_seen);
        $display("a table filled to %0d slots with backup and restore over it.", SLOT_LIMIT);
        if (error_count == 0) begin
            $display("output_port_shadow_registry_core_tb: clean");
        end else begin
            $display("output_port_shadow_registry_core_tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/osr_pkg.sv
hw/rtl/osr_store.sv
hw/rtl/osr_alu.sv
hw/rtl/output_port_shadow_registry_core.sv
bench/output_port_shadow_registry_core_tb.sv
